// ===== hw/rtl/dual_sum_checksum64_top_assert.svh =====
// Assertion macros for the dual-sum checksum block and its checker.
`ifndef DUAL_SUM_CHECKSUM64_TOP_ASSERT_SVH
`define DUAL_SUM_CHECKSUM64_TOP_ASSERT_SVH

// Concurrent assertion on the block clock, disabled while reset is held.
`define DSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent must hold in the cycle after the antecedent.
`define DSC_ASSERT_NEXT(label, ante, cons, msg) \
  `DSC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/dsc64_pkg.sv =====
// Shared struct type, constants and helper function for the dual-sum checksum block.
package dsc64_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned SumW  = 64;

  localparam logic [HalfW-1:0] Modulus = 16'd65521;

  localparam logic [WordW-1:0] WordSumInit    = 32'd1;
  localparam logic [WordW-1:0] WordSumSumInit = 32'd0;
  localparam logic [HalfW-1:0] ByteSumInit    = 16'd1;
  localparam logic [HalfW-1:0] ByteSumSumInit = 16'd0;

  // The four running sums as they stand after a word has been folded in.
  typedef struct packed {
    logic [WordW-1:0] b;
    logic [WordW-1:0] a;
    logic [HalfW-1:0] d;
    logic [HalfW-1:0] c;
  } dsc_sums_t;

  // Both operands are below the modulus, so one subtract suffices.
  function automatic logic [HalfW-1:0] mod_add(input logic [HalfW-1:0] x,
                                               input logic [HalfW-1:0] y);
    logic [HalfW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, Modulus}) begin
      s = s - {1'b0, Modulus};
    end
    return s[HalfW-1:0];
  endfunction

endpackage

// ===== hw/rtl/dual_sum_checksum64_top.sv =====
// A final word passes the input, final-sum and output registers before its checksum appears.
// One word per cycle unless a final word waits for the final-sum register; the sums update as a word is taken.
// The input, final-sum and output registers form an elastic pipe, so words keep
// flowing while a checksum waits to be taken.
// Reset empties the pipe and sets the sums to 1, 0, 1 and 0.
module dual_sum_checksum64_top import dsc64_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WordW-1:0]  word_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [SumW-1:0]   checksum_o
);

  logic              in_valid_q, in_valid_d;
  logic [WordW-1:0]  word_q;
  logic              last_q;
  logic              fin_ready;
  logic              take;
  logic              in_accept;
  dsc_sums_t         sums;

  // A word that does not end a message never needs room further down.
  assign take       = in_valid_q && (!last_q || fin_ready);
  assign in_ready_o = !in_valid_q || take;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (take) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q <= word_i;
      last_q <= last_i;
    end
  end

  dsc64_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .word_i (word_q),
    .last_i (last_q),
    .sums_o (sums)
  );

  dsc64_combine u_combine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && last_q),
    .sums_i      (sums),
    .ready_o     (fin_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .checksum_o  (checksum_o)
  );

endmodule

// ===== hw/rtl/dsc64_accum.sv =====
// Running-sum registers and their per-word update.
module dsc64_accum import dsc64_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [WordW-1:0]    word_i,
  input  logic                last_i,
  output dsc_sums_t           sums_o
);

  logic [WordW-1:0] a_q, a_d;
  logic [WordW-1:0] b_q, b_d;
  logic [HalfW-1:0] c_q, c_d;
  logic [HalfW-1:0] d_q, d_d;

  always_comb begin
    a_d = a_q + word_i;
    b_d = b_q + a_d;
    c_d = mod_add(c_q, {{(HalfW-8){1'b0}}, word_i[7:0]});
    d_d = mod_add(d_q, c_d);
  end

  assign sums_o = '{b: b_d, a: a_d, d: d_d, c: c_d};

  // The final word of a message leaves the sums at their starting values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= WordSumInit;
      b_q <= WordSumSumInit;
      c_q <= ByteSumInit;
      d_q <= ByteSumSumInit;
    end else if (take_i) begin
      if (last_i) begin
        a_q <= WordSumInit;
        b_q <= WordSumSumInit;
        c_q <= ByteSumInit;
        d_q <= ByteSumSumInit;
      end else begin
        a_q <= a_d;
        b_q <= b_d;
        c_q <= c_d;
        d_q <= d_d;
      end
    end
  end

endmodule

// ===== hw/rtl/dsc64_combine.sv =====
// Final-sum register, 64-bit combining add and output register.
module dsc64_combine import dsc64_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  dsc_sums_t          sums_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SumW-1:0]    checksum_o
);

  dsc_sums_t         sums_q;
  logic              fin_valid_q, fin_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [SumW-1:0]   checksum_q;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign ready_o  = !fin_valid_q || out_free;

  always_comb begin
    fin_valid_d = fin_valid_q;
    if (load_i) begin
      fin_valid_d = 1'b1;
    end else if (out_free) begin
      fin_valid_d = 1'b0;
    end
    out_valid_d = out_free ? fin_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sums_q <= sums_i;
    end
    if (out_free && fin_valid_q) begin
      checksum_q <= {sums_q.b, sums_q.a} + {{(SumW-2*HalfW){1'b0}}, sums_q.d, sums_q.c};
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

endmodule

// ===== hw/rtl/dsc64_checker.sv =====
// Port-level checker for the dual-sum checksum block, bound to the top level.
`include "dual_sum_checksum64_top_assert.svh"

module dsc64_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic last_in;

  assign last_in = in_valid_i && in_ready_i && in_last_i;

  // A pending checksum stays offered until it is taken.
  `DSC_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "out_valid dropped")

  // The input side stalls only when every stage is full behind a stalled output.
  `DSC_ASSERT(a_in_stall_cause, !in_ready_i |-> (out_valid_i && !out_ready_i), "input stalled")

  // A checksum cannot be offered before a final word has passed the input and final-sum registers.
  `DSC_ASSERT_NEXT(a_min_latency, !out_valid_i && !$past(last_in, 2), !out_valid_i, "early checksum")

endmodule

bind dual_sum_checksum64_top dsc64_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_last_i   (last_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i)
);
